>>> design/g6dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g6dec_pkg
// Shared types and constants for the graph6 adjacency decoder.
// ----------------------------------------------------------------------------
package g6dec_pkg;

  localparam int unsigned MAX_VERTICES = 62;

  localparam logic [7:0] G6_OFFSET  = 8'd63;
  localparam logic [7:0] HDR_HIGH   = 8'(63 + MAX_VERTICES);
  localparam int unsigned G6_BITS   = 6;
  localparam logic [2:0] LAST_BIT   = 3'(G6_BITS - 1);

  localparam int unsigned VTX_W     = 6;
  localparam int unsigned CNT_W     = 11;

  // Byte queue between front and back.
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = 1;
  localparam int unsigned QFILL_W   = 2;

  typedef enum logic {
    PH_HEADER    = 1'b0,
    PH_ADJACENCY = 1'b1
  } g6_phase_t;

  // One classified byte as it waits in the queue.
  typedef struct packed {
    logic [G6_BITS-1:0] bits;    // (byte - 63) mod 64
    logic               hdr_ok;  // byte lies in 63..63+MAX_VERTICES
    logic               tiny;    // valid header with fewer than two vertices
  } g6_item_t;

endpackage

>>> design/g6dec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g6dec_front
// Accepts raw bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module g6dec_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  output logic               q_valid,
  output g6dec_pkg::g6_item_t q_item,
  input  logic               q_pop
);
  import g6dec_pkg::*;

  g6_item_t              fifo_mem [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QFILL_W-1:0]    fill;
  g6_item_t              item_new;
  logic [7:0]            offset_byte;
  logic                  push;
  logic                  pop;

  assign offset_byte = data_byte - G6_OFFSET;

  always_comb begin
    item_new.bits   = offset_byte[G6_BITS-1:0];
    item_new.hdr_ok = (data_byte >= G6_OFFSET) && (data_byte <= HDR_HIGH);
    item_new.tiny   = item_new.hdr_ok && (offset_byte < 8'd2);
  end

  assign in_ready = (fill != QFILL_W'(QDEPTH));
  assign q_valid  = (fill != '0);
  assign q_item   = fifo_mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= item_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> design/g6dec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g6dec_back
// Walks the upper triangle into an output register, one adjacency bit per
// cycle while a byte waits and the output register is free.
// ----------------------------------------------------------------------------
module g6dec_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  g6dec_pkg::g6_item_t          q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         edge_valid,
  output logic [g6dec_pkg::VTX_W-1:0]  row_u,
  output logic [g6dec_pkg::VTX_W-1:0]  col_v,
  output logic                         edge_present,
  output logic [g6dec_pkg::CNT_W-1:0]  uncoloured_count,
  output logic                         graph_done,
  output logic                         last_in_run,
  output logic                         bad_header
);
  import g6dec_pkg::*;

  g6_phase_t          phase;
  g6_phase_t          phase_next;
  logic [2:0]         bit_idx;
  logic [VTX_W-1:0]   vertex_count;
  logic [VTX_W-1:0]   pair_low;
  logic [VTX_W-1:0]   pair_high;
  logic [CNT_W-1:0]   present_total;

  logic               slot_free;
  logic               go;
  logic               emit;
  logic               load_hdr;
  logic               adj_step;
  logic               cur_bit;
  logic [VTX_W-1:0]   low_inc;
  logic [VTX_W-1:0]   high_inc;
  logic               wrap;
  logic               done;
  logic               last;
  logic [CNT_W-1:0]   total_inc;

  assign slot_free = !out_valid || out_ready;
  assign go        = q_valid && slot_free;

  assign cur_bit   = q_item.bits[LAST_BIT - bit_idx];
  assign low_inc   = pair_low + 1'b1;
  assign high_inc  = pair_high + 1'b1;
  assign wrap      = (low_inc >= pair_high);
  assign done      = wrap && (high_inc >= vertex_count);
  assign last      = done || (bit_idx == LAST_BIT);
  assign total_inc = present_total + CNT_W'(cur_bit);

  // Step decode.
  always_comb begin
    emit     = 1'b0;
    load_hdr = 1'b0;
    adj_step = 1'b0;
    q_pop    = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (go) begin
          q_pop = 1'b1;
          if (!q_item.hdr_ok || q_item.tiny) begin
            emit = 1'b1;
          end else begin
            load_hdr = 1'b1;
          end
        end
      end
      PH_ADJACENCY: begin
        if (go) begin
          emit     = 1'b1;
          adj_step = 1'b1;
          q_pop    = last;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HEADER: begin
        if (load_hdr) begin
          phase_next = PH_ADJACENCY;
        end
      end
      PH_ADJACENCY: begin
        if (adj_step && done) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      bit_idx       <= '0;
      vertex_count  <= '0;
      pair_low      <= '0;
      pair_high     <= VTX_W'(1);
      present_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load_hdr) begin
        vertex_count  <= q_item.bits;
        pair_low      <= '0;
        pair_high     <= VTX_W'(1);
        present_total <= '0;
        bit_idx       <= '0;
      end else if (adj_step) begin
        present_total <= total_inc;
        bit_idx       <= last ? 3'd0 : bit_idx + 3'd1;
        if (done) begin
          pair_low  <= '0;
          pair_high <= VTX_W'(1);
        end else if (wrap) begin
          pair_low  <= '0;
          pair_high <= high_inc;
        end else begin
          pair_low <= low_inc;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; header results carry zeros in the edge fields.
  always_ff @(posedge clk) begin
    if (emit) begin
      edge_valid       <= adj_step;
      row_u            <= adj_step ? pair_low : '0;
      col_v            <= adj_step ? pair_high : '0;
      edge_present     <= adj_step && cur_bit;
      uncoloured_count <= adj_step ? total_inc : '0;
      graph_done       <= adj_step ? done : 1'b1;
      last_in_run      <= adj_step ? last : 1'b1;
      bad_header       <= !adj_step && !q_item.hdr_ok;
    end
  end

endmodule

>>> design/graph6_adjacency_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph6_adjacency_decoder
// Decodes graph6: a result per upper-triangle pair or rejected/tiny header.
// ----------------------------------------------------------------------------
//  Channel  Signals                        Carries
//  input    in_valid / in_ready            data_byte, header or six-bit group
//  output   out_valid / out_ready          one edge or header-end result
//
// A valid header of two or more vertices gives no result. A rejected or tiny
// header gives one result. An adjacency byte gives up to six results, one per
// cycle while the output register is free, set by the single-pair sequencer
// in the back end. A two-entry byte queue lets input be taken while the
// sequencer works, and the output register frees each cycle its result is
// taken. Synchronous reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module graph6_adjacency_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         edge_valid,
  output logic [g6dec_pkg::VTX_W-1:0]  row_u,
  output logic [g6dec_pkg::VTX_W-1:0]  col_v,
  output logic                         edge_present,
  output logic [g6dec_pkg::CNT_W-1:0]  uncoloured_count,
  output logic                         graph_done,
  output logic                         last_in_run,
  output logic                         bad_header
);
  import g6dec_pkg::*;

  logic      q_valid;
  g6_item_t  q_item;
  logic      q_pop;

  g6dec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  g6dec_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .edge_valid       (edge_valid),
    .row_u            (row_u),
    .col_v            (col_v),
    .edge_present     (edge_present),
    .uncoloured_count (uncoloured_count),
    .graph_done       (graph_done),
    .last_in_run      (last_in_run),
    .bad_header       (bad_header)
  );

endmodule

>>> design/g6dec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g6dec_checker
// Port-level checks on the result stream of the graph6 decoder.
// ----------------------------------------------------------------------------
module g6dec_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         edge_valid,
  input  logic [g6dec_pkg::VTX_W-1:0]  row_u,
  input  logic [g6dec_pkg::VTX_W-1:0]  col_v,
  input  logic [g6dec_pkg::CNT_W-1:0]  uncoloured_count,
  input  logic                         graph_done,
  input  logic                         last_in_run,
  input  logic                         bad_header
);

  // A waiting result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // A header result ends both the graph and the byte.
  a_hdr_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !edge_valid |-> graph_done && last_in_run)
    else $error("header result does not end graph and byte");

  // A bad header never reports an edge.
  a_bad_noedge: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_header |-> !edge_valid)
    else $error("bad header flagged on an edge result");

  // Edge pairs stay in the upper triangle.
  a_upper: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_valid |-> row_u < col_v)
    else $error("edge pair outside upper triangle");

  // Header results carry zeroed edge fields.
  a_hdr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !edge_valid |-> row_u == '0 && col_v == '0 && uncoloured_count == '0)
    else $error("header result carries edge data");

endmodule

bind graph6_adjacency_decoder g6dec_checker u_g6dec_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .edge_valid       (edge_valid),
  .row_u            (row_u),
  .col_v            (col_v),
  .uncoloured_count (uncoloured_count),
  .graph_done       (graph_done),
  .last_in_run      (last_in_run),
  .bad_header       (bad_header)
);

>>> bench/tb_graph6_adjacency_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph6_adjacency_decoder
// Self-checking bench for the graph6 adjacency decoder. A clocked driver
// feeds bytes from a queue and predicts each transfer's edge results. A
// clocked monitor compares every output transfer with the oldest prediction.
// The run covers header corner cases, small random graphs with noise, and
// a broken-off 62-vertex graph, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_graph6_adjacency_decoder;

  import g6dec_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic             edge_valid;
    logic [VTX_W-1:0] row_u;
    logic [VTX_W-1:0] col_v;
    logic             edge_present;
    logic [CNT_W-1:0] uncoloured_count;
    logic             graph_done;
    logic             last_in_run;
    logic             bad_header;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic edge_valid;
  logic [VTX_W-1:0] row_u;
  logic [VTX_W-1:0] col_v;
  logic edge_present;
  logic [CNT_W-1:0] uncoloured_count;
  logic graph_done;
  logic last_in_run;
  logic bad_header;

  logic [7:0] byte_stream[$];
  edge_result_t expected_edges[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Decoder state as the bench tracks it.
  g6_phase_t        dec_phase = PH_HEADER;
  logic [VTX_W-1:0] dec_vertices = '0;
  logic [VTX_W-1:0] dec_low = '0;
  logic [VTX_W-1:0] dec_high = 6'd1;
  logic [CNT_W-1:0] dec_total = '0;

  edge_result_t got_edge;
  edge_result_t want_edge;

  graph6_adjacency_decoder i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .edge_valid       (edge_valid),
    .row_u            (row_u),
    .col_v            (col_v),
    .edge_present     (edge_present),
    .uncoloured_count (uncoloured_count),
    .graph_done       (graph_done),
    .last_in_run      (last_in_run),
    .bad_header       (bad_header)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the results of one accepted byte and queues them.
  function automatic void decode_byte(input logic [7:0] b);
    edge_result_t r;
    logic [G6_BITS-1:0] bits;
    logic bit_val;
    logic done;
    int i;
    r = '{default: '0};
    if (dec_phase == PH_HEADER) begin
      if (b < G6_OFFSET || b > HDR_HIGH) begin
        r.graph_done = 1'b1;
        r.last_in_run = 1'b1;
        r.bad_header = 1'b1;
        expected_edges.push_back(r);
      end else if (b - G6_OFFSET < 2) begin
        r.graph_done = 1'b1;
        r.last_in_run = 1'b1;
        expected_edges.push_back(r);
      end else begin
        dec_vertices = VTX_W'(b - G6_OFFSET);
        dec_low = '0;
        dec_high = 6'd1;
        dec_total = '0;
        dec_phase = PH_ADJACENCY;
      end
    end else begin
      bits = G6_BITS'(b - G6_OFFSET);
      done = 1'b0;
      i = 0;
      while (i < G6_BITS && !done) begin
        bit_val = bits[G6_BITS-1-i];
        r.edge_valid = 1'b1;
        r.row_u = dec_low;
        r.col_v = dec_high;
        r.edge_present = bit_val;
        dec_total = dec_total + CNT_W'(bit_val);
        r.uncoloured_count = dec_total;
        dec_low = dec_low + 1'b1;
        if (dec_low >= dec_high) begin
          dec_low = '0;
          dec_high = dec_high + 1'b1;
          done = (dec_high >= dec_vertices);
        end
        r.graph_done = done;
        r.last_in_run = done || (i == G6_BITS - 1);
        r.bad_header = 1'b0;
        expected_edges.push_back(r);
        i++;
      end
      if (done) begin
        dec_phase = PH_HEADER;
        dec_low = '0;
        dec_high = 6'd1;
      end
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Queues a graph of n vertices. Each adjacency bit is set with probability
  // ones_pct, and any of the four equivalent byte encodings may be used.
  // A non-negative keep cuts the graph short after that many bytes.
  task automatic queue_graph(input int n, input int ones_pct, input int keep,
                             output int added);
    int pairs;
    int nbytes;
    logic [G6_BITS-1:0] bits;
    byte_stream.push_back(8'(63 + n));
    pairs = n * (n - 1) / 2;
    nbytes = (pairs + G6_BITS - 1) / G6_BITS;
    if (keep >= 0 && keep < nbytes) nbytes = keep;
    for (int k = 0; k < nbytes; k++) begin
      for (int j = 0; j < G6_BITS; j++) bits[j] = ($urandom_range(99) < ones_pct);
      if ($urandom_range(99) < 80)
        byte_stream.push_back(8'(63 + bits));
      else
        byte_stream.push_back(8'(63 + bits + 64 * $urandom_range(3)));
    end
    added = nbytes + 1;
  endtask

  task automatic queue_random_part(input int budget);
    int added;
    int n;
    int pick;
    int total;
    total = 0;
    while (total < budget) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        byte_stream.push_back(8'($urandom_range(255)));
        added = 1;
      end else begin
        if (pick < 65) n = $urandom_range(2, 8);
        else if (pick < 90) n = $urandom_range(9, 20);
        else n = $urandom_range(21, 40);
        // Some graphs are broken off early, so the next header is read as data.
        queue_graph(n, $urandom_range(10, 90),
                    ($urandom_range(99) < 6) ? $urandom_range(0, 2) : -1, added);
      end
      total += added;
    end
  endtask

  task automatic wait_idle();
    while (byte_stream.size() != 0 || in_valid || expected_edges.size() != 0)
      @(posedge clk);
  endtask

  // Driver: presents queued bytes and predicts each transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(data_byte);
      if (!in_valid || in_ready) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          data_byte <= byte_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks every output transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_edge = '{edge_valid, row_u, col_v, edge_present, uncoloured_count,
                   graph_done, last_in_run, bad_header};
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual u=%0d v=%0d",
                 $time, row_u, col_v);
        mismatches++;
      end else begin
        want_edge = expected_edges.pop_front();
        check_field("edge_valid", want_edge.edge_valid, got_edge.edge_valid);
        check_field("row_u", want_edge.row_u, got_edge.row_u);
        check_field("col_v", want_edge.col_v, got_edge.col_v);
        check_field("edge_present", want_edge.edge_present, got_edge.edge_present);
        check_field("uncoloured_count", want_edge.uncoloured_count,
                    got_edge.uncoloured_count);
        check_field("graph_done", want_edge.graph_done, got_edge.graph_done);
        check_field("last_in_run", want_edge.last_in_run, got_edge.last_in_run);
        check_field("bad_header", want_edge.bad_header, got_edge.bad_header);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("graph6_adjacency_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    int added;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: header corners, tiny graphs, exact fill and padding.
    byte_stream.push_back(8'd0);
    byte_stream.push_back(8'd255);
    byte_stream.push_back(8'd62);
    byte_stream.push_back(8'd126);
    byte_stream.push_back(8'd63);
    byte_stream.push_back(8'd64);
    byte_stream.push_back(8'd65);   // two vertices, one pair
    byte_stream.push_back(8'd126);
    byte_stream.push_back(8'd66);   // three vertices, all absent
    byte_stream.push_back(8'd255);
    byte_stream.push_back(8'd67);   // four vertices fill one byte exactly
    byte_stream.push_back(8'd126);
    byte_stream.push_back(8'd68);   // five vertices; the set low bit is padding
    byte_stream.push_back(8'd63);
    byte_stream.push_back(8'd0);
    queue_graph(7, 50, -1, added);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      queue_random_part(50);
      // The largest legal header, followed by a few all-ones bytes.
      if (ph == 3) queue_graph(MAX_VERTICES, 100, 4, added);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_edges.size() == 0) begin
      $display("graph6_adjacency_decoder regression: pass");
    end else begin
      $display("graph6_adjacency_decoder regression: fail");
    end
    $finish;
  end

endmodule
